>>> rtl/eoq_pkg.sv
`default_nettype none

package eoq_pkg;

  localparam int FLOORS   = 4;
  localparam int BUTTONS  = 3;
  localparam int DEPTH    = FLOORS * BUTTONS;

  localparam int KIND_W   = 2;
  localparam int FLOOR_W  = 2;
  localparam int BUTTON_W = 2;
  localparam int LEN_W    = 4;
  localparam int ENTRY_W  = FLOOR_W + BUTTON_W;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS  = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  localparam logic [BUTTON_W-1:0] BTN_UP   = 2'd0;
  localparam logic [BUTTON_W-1:0] BTN_DOWN = 2'd1;

  typedef struct packed {
    logic [BUTTON_W-1:0] button;
    logic [FLOOR_W-1:0]  floor;
  } entry_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SCAN_RD,
    DP_DUP_CHK,
    DP_SHIFT_INIT,
    DP_SHIFT_WR,
    DP_INSERT,
    DP_CMP,
    DP_FINISH,
    DP_EMIT_RD,
    DP_EMIT,
    DP_EMIT_NULL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_press;
    logic count_zero;
    logic scan_last;
    logic idx_zero;
    logic press_ok;
    logic front;
    logic nl_zero;
    logic emit_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/elevator_order_queue.sv
// A queued press is checked for duplicates against every stored order and, when it goes to the
// front, shifts the stored orders down first; a refused press, a floor removal that matches
// nothing, or a pop, removal or clear on an empty queue yields one result with no lamp change;
// otherwise one result per lamp. Scans go through the single read port of the order store.
// The next word is accepted only once the last result of the current word is registered.
// Synchronous active-low reset empties the queue and idles the controller, not the store.
`default_nettype none

module elevator_order_queue
  import eoq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // order_floor[1:0], order_button[3:2], last_floor[5:4], zero fill above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  wire logic [KIND_W-1:0]     in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // lamp_floor[1:0], lamp_button[3:2], lamp_on[4], queue_length[8:5],
  // head_floor[10:9], head_button[12:11], queue_empty[13], zero fill above
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // lamp_valid
  output logic                       out_tuser,
  output logic                       out_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;

  eoq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  eoq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/eoq_ram.sv
`default_nettype none

module eoq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/eoq_dp.sv
`default_nettype none

module eoq_dp
  import eoq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [KIND_W-1:0]     in_tuser,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  // Latched command word.
  kind_t                 kind_r;
  logic [FLOOR_W-1:0]    floor_r;
  logic [BUTTON_W-1:0]   button_r;
  logic [FLOOR_W-1:0]    lastf_r;

  // Queue bookkeeping.
  logic [CNT_W-1:0]      count_r, count_nxt;
  entry_t                head_r, head_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      keep_r, keep_nxt;
  logic [CNT_W-1:0]      nl_r, nl_nxt;
  entry_t                newhead_r, newhead_nxt;
  logic                  dup_r, dup_nxt;

  // Output register.
  logic                  out_valid_r;
  logic                  o_lamp_valid_r;
  entry_t                o_lamp_r;
  logic                  o_lamp_on_r;
  logic [LEN_W-1:0]      o_len_r;
  entry_t                o_head_r;
  logic                  o_empty_r;
  logic                  o_last_r;

  entry_t                new_entry;
  entry_t                slot_rdata;
  entry_t                lamp_rdata;
  logic                  slot_we, lamp_we;
  logic [IDX_W-1:0]      slot_waddr, lamp_waddr;
  entry_t                slot_wdata, lamp_wdata;
  logic                  match;
  logic                  front;
  logic                  count_zero;
  logic [IDX_W-1:0]      ins_pos;

  function automatic logic rule_holds(
    input logic [FLOOR_W-1:0]  hf,
    input logic [FLOOR_W-1:0]  nf,
    input logic [BUTTON_W-1:0] nb,
    input logic [FLOOR_W-1:0]  lf
  );
    logic up;
    logic down;
    up   = (hf > nf) && (lf < nf);
    down = (hf < nf) && (lf > nf);
    case (nb)
      BTN_UP:   return up;
      BTN_DOWN: return down;
      default:  return up || down;
    endcase
  endfunction

  assign new_entry  = '{button: button_r, floor: floor_r};
  assign count_zero = (count_r == '0);
  assign front      = !count_zero && rule_holds(head_r.floor, floor_r, button_r, lastf_r);
  assign ins_pos    = front ? '0 : count_r[IDX_W-1:0];

  // Which stored orders a compaction pass drops.
  always_comb begin
    case (kind_r)
      KIND_POP:    match = (idx_r == '0);
      KIND_REMOVE: match = (slot_rdata.floor == floor_r);
      KIND_CLEAR:  match = 1'b1;
      default:     match = 1'b0;
    endcase
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = keep_r[IDX_W-1:0];
    slot_wdata = slot_rdata;
    lamp_we    = 1'b0;
    lamp_waddr = nl_r[IDX_W-1:0];
    lamp_wdata = slot_rdata;
    case (cmd.op)
      DP_SHIFT_WR: begin
        slot_we    = 1'b1;
        slot_waddr = IDX_W'(idx_r + 1'b1);
      end
      DP_INSERT: begin
        slot_we    = 1'b1;
        slot_waddr = ins_pos;
        slot_wdata = new_entry;
        lamp_we    = 1'b1;
        lamp_waddr = '0;
        lamp_wdata = new_entry;
      end
      DP_CMP: begin
        slot_we = !match;
        lamp_we = match;
      end
      default: ;
    endcase
  end

  eoq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.op == DP_SCAN_RD),
    .raddr (idx_r),
    .rdata (slot_rdata)
  );

  // Lamp changes of the current word, in queue order, until they are sent.
  eoq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_lamps (
    .clk   (clk),
    .we    (lamp_we),
    .waddr (lamp_waddr),
    .wdata (lamp_wdata),
    .re    (cmd.op == DP_EMIT_RD),
    .raddr (idx_r),
    .rdata (lamp_rdata)
  );

  always_comb begin
    count_nxt   = count_r;
    head_nxt    = head_r;
    idx_nxt     = idx_r;
    keep_nxt    = keep_r;
    nl_nxt      = nl_r;
    newhead_nxt = newhead_r;
    dup_nxt     = dup_r;
    case (cmd.op)
      DP_LOAD: begin
        idx_nxt  = '0;
        keep_nxt = '0;
        nl_nxt   = '0;
        dup_nxt  = 1'b0;
      end
      DP_DUP_CHK: begin
        if (slot_rdata == new_entry) begin
          dup_nxt = 1'b1;
        end
        idx_nxt = IDX_W'(idx_r + 1'b1);
      end
      DP_SHIFT_INIT: idx_nxt = IDX_W'(count_r - 1'b1);
      DP_SHIFT_WR:   idx_nxt = IDX_W'(idx_r - 1'b1);
      DP_INSERT: begin
        if (front || count_zero) begin
          head_nxt = new_entry;
        end
        count_nxt = CNT_W'(count_r + 1'b1);
        nl_nxt    = CNT_W'(1);
        idx_nxt   = '0;
      end
      DP_CMP: begin
        if (match) begin
          nl_nxt = CNT_W'(nl_r + 1'b1);
        end else begin
          if (keep_r == '0) begin
            newhead_nxt = slot_rdata;
          end
          keep_nxt = CNT_W'(keep_r + 1'b1);
        end
        idx_nxt = IDX_W'(idx_r + 1'b1);
      end
      DP_FINISH: begin
        count_nxt = keep_r;
        head_nxt  = newhead_r;
        idx_nxt   = '0;
      end
      DP_EMIT: idx_nxt = IDX_W'(idx_r + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      keep_r      <= '0;
      nl_r        <= '0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      keep_r  <= keep_nxt;
      nl_r    <= nl_nxt;
      dup_r   <= dup_nxt;
      if (cmd.op == DP_EMIT || cmd.op == DP_EMIT_NULL) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r    <= head_nxt;
    newhead_r <= newhead_nxt;
    if (cmd.op == DP_LOAD) begin
      kind_r   <= kind_t'(in_tuser);
      floor_r  <= in_tdata[FLOOR_W-1:0];
      button_r <= in_tdata[FLOOR_W +: BUTTON_W];
      lastf_r  <= in_tdata[FLOOR_W+BUTTON_W +: FLOOR_W];
    end
    if (cmd.op == DP_EMIT || cmd.op == DP_EMIT_NULL) begin
      o_lamp_valid_r <= (cmd.op == DP_EMIT);
      o_lamp_r       <= (cmd.op == DP_EMIT) ? lamp_rdata : '0;
      o_lamp_on_r    <= (cmd.op == DP_EMIT) && (kind_r == KIND_PRESS);
      o_last_r       <= (cmd.op == DP_EMIT_NULL) || status.emit_last;
      o_len_r        <= LEN_W'(count_r);
      o_head_r       <= count_zero ? '0 : head_r;
      o_empty_r      <= count_zero;
    end
  end

  assign status.is_press   = (kind_r == KIND_PRESS);
  assign status.count_zero = count_zero;
  assign status.scan_last  = (CNT_W'(idx_r) == CNT_W'(count_r - 1'b1));
  assign status.idx_zero   = (idx_r == '0);
  assign status.press_ok   = (int'(button_r) < BUTTONS) && (int'(floor_r) < FLOORS) &&
                             !dup_r && (int'(count_r) < DEPTH);
  assign status.front      = front;
  assign status.nl_zero    = (nl_r == '0);
  assign status.emit_last  = (CNT_W'(idx_r) == CNT_W'(nl_r - 1'b1));
  assign status.out_busy   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_lamp_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_empty_r, o_head_r.button, o_head_r.floor, o_len_r,
                       o_lamp_on_r, o_lamp_r.button, o_lamp_r.floor};

`ifndef SYNTH
  // During compaction every visited slot was either kept or dropped.
  a_scan_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_CMP) |-> (CNT_W'(keep_r + nl_r) == CNT_W'(idx_r)))
    else $error("compaction counters out of step with the scan index");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("order count exceeds the queue depth");

  // A word with no lamp change is always the only result of its input.
  a_null_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_lamp_valid_r) |-> o_last_r)
    else $error("lamp-less result not marked last");
`endif

endmodule

`default_nettype wire

>>> rtl/eoq_ctrl.sv
`default_nettype none

module eoq_ctrl
  import eoq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DUP_RD,
    S_DUP_USE,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_USE,
    S_INSERT,
    S_CMP_RD,
    S_CMP_USE,
    S_FINISH,
    S_EMIT_RD,
    S_EMIT_USE,
    S_EMIT_NULL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (status.is_press) begin
          state_nxt = status.count_zero ? S_DECIDE : S_DUP_RD;
        end else begin
          state_nxt = status.count_zero ? S_EMIT_NULL : S_CMP_RD;
        end
      end
      S_DUP_RD: begin
        cmd.op    = DP_SCAN_RD;
        state_nxt = S_DUP_USE;
      end
      S_DUP_USE: begin
        cmd.op    = DP_DUP_CHK;
        state_nxt = status.scan_last ? S_DECIDE : S_DUP_RD;
      end
      S_DECIDE: begin
        if (!status.press_ok) begin
          state_nxt = S_EMIT_NULL;
        end else if (status.front) begin
          cmd.op    = DP_SHIFT_INIT;
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_SHIFT_RD: begin
        cmd.op    = DP_SCAN_RD;
        state_nxt = S_SHIFT_USE;
      end
      S_SHIFT_USE: begin
        cmd.op    = DP_SHIFT_WR;
        state_nxt = status.idx_zero ? S_INSERT : S_SHIFT_RD;
      end
      S_INSERT: begin
        cmd.op    = DP_INSERT;
        state_nxt = S_EMIT_RD;
      end
      S_CMP_RD: begin
        cmd.op    = DP_SCAN_RD;
        state_nxt = S_CMP_USE;
      end
      S_CMP_USE: begin
        cmd.op    = DP_CMP;
        state_nxt = status.scan_last ? S_FINISH : S_CMP_RD;
      end
      S_FINISH: begin
        cmd.op    = DP_FINISH;
        state_nxt = status.nl_zero ? S_EMIT_NULL : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd.op    = DP_EMIT_RD;
        state_nxt = S_EMIT_USE;
      end
      S_EMIT_USE: begin
        if (!status.out_busy) begin
          cmd.op    = DP_EMIT;
          state_nxt = status.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_EMIT_NULL: begin
        if (!status.out_busy) begin
          cmd.op    = DP_EMIT_NULL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

`default_nettype wire
